[design/render_interval_pacing_controller_macros.svh]
// ----------------------------------------------------------------------------
// render_interval_pacing_controller_macros
// Assertion helpers of the pacing controller.
// ----------------------------------------------------------------------------
`ifndef RENDER_INTERVAL_PACING_CONTROLLER_MACROS_SVH
`define RENDER_INTERVAL_PACING_CONTROLLER_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define RIPC_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ripc check failed");

// Next-cycle implication checked outside reset.
`define RIPC_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ripc check failed");

`endif

[design/ripc_pkg.sv]
// ----------------------------------------------------------------------------
// ripc_pkg
// Shared widths, register indexes and percentage constants of the pacing controller.
// ----------------------------------------------------------------------------
package ripc_pkg;
   localparam int SrcWidth  = 12;
   localparam int SpanWidth = 16;
   localparam int PctWidth  = 7;
   localparam int IvlWidth  = 13;
   localparam int CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_BASE   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SMOOTH = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE  = 2'd3;

   localparam logic [7:0] PctHundred = 8'd100;
   localparam logic [7:0] PctKeep    = 8'd108;

   typedef logic [SrcWidth-1:0]  src_type;
   typedef logic [SpanWidth-1:0] span_type;
   typedef logic [PctWidth-1:0]  pct_type;
   typedef logic [IvlWidth-1:0]  ivl_type;
endpackage

[design/render_interval_pacing_controller.sv]
// ----------------------------------------------------------------------------
// render_interval_pacing_controller
// Per-frame render interval from latency error, backlog tiers and smoothing.
// ----------------------------------------------------------------------------
// One transaction at a time: a new one is taken only after the last result leaves.
// A restoring divider forms the error ratio one quotient bit per cycle, a
// multiply step scales it by the base percentage and clamps it, a product step
// forms the interval products, four bit-serial divisions by 100 run side by side
// (stall floor, both bounds and the desired interval), a blend step clamps the
// desired interval and forms the blend, a second division by 100 divides the
// blend and a final step clamps and stores it. A stalled result holds the
// block; the next transaction is taken once the result has left.
`include "render_interval_pacing_controller_macros.svh"
module render_interval_pacing_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ripc_pkg::src_type    req_source_interval,
   input  ripc_pkg::span_type   req_buffered_span,
   input  ripc_pkg::span_type   req_target_latency,
   input  logic                 req_stall_active,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ripc_pkg::ivl_type    rsp_desired_interval,
   output ripc_pkg::ivl_type    rsp_render_interval,
   input  logic                 csr_write,
   input  logic [ripc_pkg::CsrIdxWidth-1:0] csr_index,
   input  ripc_pkg::pct_type    csr_data
);
   import ripc_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_PROD  = 4'd3;
   localparam logic [3:0] ST_DIVA  = 4'd4;
   localparam logic [3:0] ST_BLEND = 4'd5;
   localparam logic [3:0] ST_DIVB  = 4'd6;
   localparam logic [3:0] ST_FIN   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   pct_type base_ff, max_ff, smooth_ff;
   src_type src_ff;
   span_type span_ff, tgt_ff;
   logic stall_ff, neg_ff, sat_ff;
   logic [17:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [16:0] err_trial;
   logic signed [28:0] adj_ff;
   logic [19:0] keep_w_ff, lo_w_ff, hi_w_ff, acc_w_ff;
   ivl_type prev_ff, des_ff, ren_ff;
   logic rsp_valid_ff;

   src_type src_req;
   logic [15:0] diff_req;
   logic sat_req;

   // Configuration values as the datapath sees them.
   logic [6:0] base_eff, max_eff, sm_eff;
   always_comb begin
      base_eff = (base_ff > 7'd100) ? 7'd100 : base_ff;
      sm_eff   = (smooth_ff > 7'd100) ? 7'd100 : smooth_ff;
      max_eff  = (max_ff > 7'd100) ? 7'd100 : max_ff;
      if (max_eff < base_eff) max_eff = base_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 7'd8; max_ff <= 7'd40; smooth_ff <= 7'd25;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE:   base_ff <= csr_data;
            CSR_MAX:    max_ff <= csr_data;
            CSR_SMOOTH: smooth_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   // One restoring step of a division by 100. The top seven bits hold the
   // remainder, the quotient bits enter at the bottom.
   function automatic logic [19:0] div100_step(logic [19:0] w);
      logic [7:0] trial;
      logic [19:0] result;
      trial = w[19:12];
      if (trial >= PctHundred) result = {7'(trial - PctHundred), w[11:0], 1'b1};
      else result = {trial[6:0], w[11:0], 1'b0};
      return result;
   endfunction

   assign src_req = (req_source_interval == '0) ? 12'd1 : req_source_interval;
   assign diff_req = (req_buffered_span >= req_target_latency)
                   ? req_buffered_span - req_target_latency
                   : req_target_latency - req_buffered_span;
   // A positive error of four or more saturates, so the quotient fits 18 bits.
   assign sat_req = (req_buffered_span >= req_target_latency)
                 && ({2'b0, diff_req} >= {req_target_latency, 2'b00});

   // Restoring division of |span - target| << 16 by target, one bit a cycle.
   always_comb begin
      err_trial = {rem_ff, quo_ff[17]};
      if (err_trial >= {1'b0, tgt_ff}) begin
         rem_in = 16'(err_trial - {1'b0, tgt_ff});
         quo_in = {quo_ff[16:0], 1'b1};
      end else begin
         rem_in = err_trial[15:0];
         quo_in = {quo_ff[16:0], 1'b0};
      end
   end

   // Error ratio, backlog cap and the scaled, clamped adjustment.
   logic signed [20:0] err_c;
   logic signed [28:0] adj_prod, adj_lo, adj_hi, adj_c;
   logic [6:0] cap_c;
   logic [19:0] s3, t3;
   logic [20:0] t5;
   logic [17:0] t2;
   always_comb begin
      if (tgt_ff == '0) err_c = '0;
      else if (neg_ff) err_c = (quo_ff > 18'd32768) ? -21'sd32768 : -$signed({3'b0, quo_ff});
      else if (sat_ff) err_c = 21'sd262144;
      else err_c = $signed({3'b0, quo_ff});
      s3 = 20'({span_ff, 1'b0});
      t3 = 20'(tgt_ff) * 20'd3;
      t2 = {1'b0, tgt_ff, 1'b0};
      t5 = 21'(tgt_ff) * 21'd5;
      cap_c = base_eff;
      if (tgt_ff != '0) begin
         if (s3 >= t3) cap_c = 7'd20;
         if ({2'b0, span_ff} >= t2) cap_c = 7'd28;
         if (20'(span_ff) >= t3) cap_c = 7'd35;
         if (21'(span_ff) >= t5) cap_c = 7'd40;
      end
      if (cap_c > max_eff) cap_c = max_eff;
      adj_prod = 29'(err_c) * $signed({22'b0, base_eff});
      adj_lo = -$signed({6'b0, base_eff, 16'b0});
      adj_hi = $signed({6'b0, cap_c, 16'b0});
      adj_c = adj_prod;
      if (adj_prod < adj_lo) adj_c = adj_lo;
      else if (adj_prod > adj_hi) adj_c = adj_hi;
   end

   // Numerators of the divisions by 100; each stays below 100 << 13.
   logic signed [28:0] f_s;
   logic [23:0] f_u;
   logic [35:0] prod_c;
   logic [19:0] des_n, keep_n, lo_n, hi_n, blend_n;
   logic [12:0] keep_c, lo_c, hi_c, d_c, r_c;
   logic floor_c;
   always_comb begin
      // 6553600 is one hundred percent in Q16.
      f_s = 29'sd6553600 - adj_ff;
      f_u = f_s[23:0];
      prod_c = 36'(src_ff) * 36'(f_u);
      des_n = 20'((prod_c + 36'd3276800) >> 16);
      keep_n = 20'(src_ff) * 20'(PctKeep) + 20'd99;
      lo_n = 20'(src_ff) * 20'(PctHundred - {1'b0, max_eff}) + 20'd99;
      hi_n = 20'(src_ff) * 20'(PctHundred + {1'b0, base_eff}) + 20'd99;

      keep_c = keep_w_ff[12:0];
      lo_c = lo_w_ff[12:0];
      hi_c = hi_w_ff[12:0];
      if (hi_c < lo_c) hi_c = lo_c;
      floor_c = stall_ff && (tgt_ff != '0)
             && (19'(span_ff) <= ((19'(tgt_ff) * 19'd5) >> 2));
      d_c = acc_w_ff[12:0];
      if (floor_c && d_c < keep_c) d_c = keep_c;
      if (d_c < lo_c) d_c = lo_c;
      if (d_c > hi_c) d_c = hi_c;
      blend_n = 20'(prev_ff) * 20'(PctHundred - {1'b0, sm_eff})
              + 20'(d_c) * 20'(sm_eff) + 20'd50;
      r_c = acc_w_ff[12:0];
      if (r_c < lo_c) r_c = lo_c;
      if (r_c > hi_c) r_c = hi_c;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin state_in = ST_DIV; cnt_in = '0; end
         ST_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd17) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_PROD;
         ST_PROD: begin state_in = ST_DIVA; cnt_in = '0; end
         ST_DIVA: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd12) state_in = ST_BLEND;
         end
         ST_BLEND: begin state_in = ST_DIVB; cnt_in = '0; end
         ST_DIVB: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd12) state_in = ST_FIN;
         end
         ST_FIN: state_in = ST_DONE;
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cnt_ff <= '0; rsp_valid_ff <= 1'b0; prev_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= (state_in == ST_DONE);
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               src_ff <= src_req;
               span_ff <= req_buffered_span; tgt_ff <= req_target_latency;
               stall_ff <= req_stall_active;
               neg_ff <= req_buffered_span < req_target_latency;
               sat_ff <= sat_req;
               rem_ff <= {2'b0, diff_req[15:2]};
               quo_ff <= {diff_req[1:0], 16'b0};
               if (prev_ff == '0) prev_ff <= {1'b0, src_req};
            end
            ST_DIV: begin rem_ff <= rem_in; quo_ff <= quo_in; end
            ST_MUL: adj_ff <= adj_c;
            ST_PROD: begin
               keep_w_ff <= keep_n; lo_w_ff <= lo_n; hi_w_ff <= hi_n; acc_w_ff <= des_n;
            end
            ST_DIVA: begin
               keep_w_ff <= div100_step(keep_w_ff);
               lo_w_ff <= div100_step(lo_w_ff);
               hi_w_ff <= div100_step(hi_w_ff);
               acc_w_ff <= div100_step(acc_w_ff);
            end
            ST_BLEND: begin des_ff <= d_c; acc_w_ff <= blend_n; end
            ST_DIVB: acc_w_ff <= div100_step(acc_w_ff);
            ST_FIN: begin ren_ff <= r_c; prev_ff <= r_c; end
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_desired_interval = des_ff;
   assign rsp_render_interval = ren_ff;

   `RIPC_ASSERT_IMP(a_valid_done, rsp_valid, state_ff == ST_DONE)
   `RIPC_ASSERT_IMP(a_busy_stall, state_ff != ST_IDLE, req_stall)
   `RIPC_ASSERT_NXT(a_fin_done, state_ff == ST_FIN, rsp_valid)
endmodule

[tb/render_interval_pacing_controller_test.sv]
// ----------------------------------------------------------------------------
// render_interval_pacing_controller_test
// Drives frame transactions with random idling on both channels, predicts the
// desired and render intervals in a local model of the pacing arithmetic and
// checks every result in order, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module render_interval_pacing_controller_test;
   import ripc_pkg::*;

   typedef struct packed {
      ivl_type desired;
      ivl_type render;
   } pacing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   src_type req_source_interval = '0;
   span_type req_buffered_span = '0;
   span_type req_target_latency = '0;
   logic req_stall_active = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ivl_type rsp_desired_interval;
   ivl_type rsp_render_interval;
   logic csr_write = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   pct_type csr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   int unsigned fail_count = 0;
   pacing_type expected_q[$];

   // Local copy of the configuration and the stored interval.
   longint cfg_base = 8, cfg_max = 40, cfg_smooth = 25;
   longint stored_interval = 0;

   render_interval_pacing_controller u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic pacing_type predict_pacing(longint src, longint span, longint tgt,
                                                 bit stalled);
      longint base, mx, sm, prev, err, adj, cap, desired, lo, hi, render, keep;
      pacing_type r;
      base = cfg_base > 100 ? 100 : cfg_base;
      mx = cfg_max;
      sm = cfg_smooth > 100 ? 100 : cfg_smooth;
      if (src == 0) src = 1;
      if (mx < base) mx = base;
      if (mx > 100) mx = 100;
      prev = stored_interval == 0 ? src : stored_interval;
      err = 0;
      if (tgt > 0) begin
         if (span >= tgt) err = ((span - tgt) * 65536) / tgt;
         else err = -(((tgt - span) * 65536) / tgt);
      end
      err = clip(err, -32768, 262144);
      adj = err * base;
      cap = base;
      if (tgt > 0) begin
         if (2 * span >= 3 * tgt) cap = 20;
         if (span >= 2 * tgt) cap = 28;
         if (span >= 3 * tgt) cap = 35;
         if (span >= 5 * tgt) cap = 40;
      end
      if (cap > mx) cap = mx;
      adj = clip(adj, -base * 65536, cap * 65536);
      desired = (src * (100 * 65536 - adj) + 50 * 65536) / (100 * 65536);
      if (stalled && tgt > 0 && span <= (tgt * 5) / 4) begin
         keep = (src * 108 + 99) / 100;
         if (desired < keep) desired = keep;
      end
      lo = (src * (100 - mx) + 99) / 100;
      hi = (src * (100 + base) + 99) / 100;
      if (hi < lo) hi = lo;
      desired = clip(desired, lo, hi);
      render = clip((prev * (100 - sm) + desired * sm + 50) / 100, lo, hi);
      stored_interval = render & 13'h1FFF;
      r.desired = ivl_type'(desired);
      r.render = ivl_type'(render);
      return r;
   endfunction

   // Valid stays high after acceptance unless the sender idles or drains.
   task automatic send_frame(src_type src, span_type span, span_type tgt, bit stalled);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_interval <= src;
      req_buffered_span <= span;
      req_target_latency <= tgt;
      req_stall_active <= stalled;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(predict_pacing(longint'(src), longint'(span), longint'(tgt),
                                          stalled));
   endtask

   // Stall is drawn anew at random each edge; results are checked at accepting edges.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result: desired %0d render %0d",
                   rsp_desired_interval, rsp_render_interval);
            fail_count++;
         end else begin
            pacing_type e;
            e = expected_q.pop_front();
            if (rsp_desired_interval !== e.desired) begin
               $error("desired_interval: expected %0d, actual %0d",
                      e.desired, rsp_desired_interval);
               fail_count++;
            end
            if (rsp_render_interval !== e.render) begin
               $error("render_interval: expected %0d, actual %0d",
                      e.render, rsp_render_interval);
               fail_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < take_idle_pct);
   end

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(logic [CsrIdxWidth-1:0] idx, pct_type value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_BASE: cfg_base = longint'(value);
         CSR_MAX: cfg_max = longint'(value);
         CSR_SMOOTH: cfg_smooth = longint'(value);
         default: ;
      endcase
   endtask

   task automatic set_registers(pct_type base, pct_type mx, pct_type sm);
      drain();
      write_register(CSR_BASE, base);
      write_register(CSR_MAX, mx);
      write_register(CSR_SMOOTH, sm);
   endtask

   task automatic test_directed;
      send_frame(12'd0, 16'd0, 16'd0, 1'b0);
      send_frame(12'hFFF, 16'hFFFF, 16'd1, 1'b0);
      send_frame(12'hFFF, 16'd0, 16'hFFFF, 1'b0);
      send_frame(12'd33, 16'd100, 16'd100, 1'b1);
      send_frame(12'd33, 16'd125, 16'd100, 1'b1);
      send_frame(12'd33, 16'd126, 16'd100, 1'b1);
      send_frame(12'd40, 16'd150, 16'd100, 1'b0);
      send_frame(12'd40, 16'd200, 16'd100, 1'b0);
      send_frame(12'd40, 16'd300, 16'd100, 1'b0);
      send_frame(12'd40, 16'd500, 16'd100, 1'b0);
      send_frame(12'd40, 16'd149, 16'd100, 1'b0);
      send_frame(12'd16, 16'd50, 16'd100, 1'b1);
      send_frame(12'd1, 16'd0, 16'd0, 1'b1);
      send_frame(12'hAAA, 16'h5555, 16'hAAAA, 1'b1);
      send_frame(12'h555, 16'hAAAA, 16'h5555, 1'b0);
   endtask

   task automatic test_random(int unsigned count);
      span_type tgt;
      span_type span;
      for (int unsigned i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: begin
               tgt = span_type'($urandom);
               span = span_type'($urandom);
            end
            default: begin
               tgt = span_type'($urandom_range(400));
               span = span_type'($urandom_range(6 * tgt + 10));
            end
         endcase
         send_frame($urandom_range(3) == 0 ? src_type'($urandom) :
                    src_type'($urandom_range(100)), span, tgt, 1'($urandom));
      end
   endtask

   task automatic test_settings;
      set_registers(7'd0, 7'd0, 7'd0);
      test_directed();
      set_registers(7'd127, 7'd127, 7'd127);
      test_directed();
      set_registers(7'd100, 7'd10, 7'd100);
      test_random(30);
      set_registers(7'd30, 7'd70, 7'd60);
      test_random(30);
      drain();
      write_register(CSR_SPARE, 7'h7F);
      test_random(10);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 9;
      take_idle_pct = 55;
      test_directed();
      test_random(100);
      send_idle_pct = 55;
      take_idle_pct = 9;
      test_settings();
      test_random(100);
      send_idle_pct = 0;
      take_idle_pct = 0;
      set_registers(7'd8, 7'd40, 7'd25);
      test_random(100);
      drain();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
